// ----- design/lpfd_pkg.sv -----
// Shared types and constants for the length-prefixed frame deframer.
// No dependencies; imported by lpfd_parser and the top level.
package lpfd_pkg;

  // Default largest accepted payload length in bytes
  localparam int unsigned MaxPayloadDef = 1024;

  // Fixed widths of the stream and result fields
  localparam int unsigned ByteW  = 8;
  localparam int unsigned HdrW   = 32;
  localparam int unsigned FrameW = 32;
  localparam int unsigned StateW = 8;
  localparam int unsigned DblW   = 64;
  localparam int unsigned OutLenW = 11;

  // Last payload offset of each field
  localparam int unsigned FrameLast    = 3;
  localparam int unsigned StateLast    = 4;
  localparam int unsigned IntervalLast = 12;
  localparam int unsigned ControlLast  = 20;
  localparam int unsigned SetpointLast = 28;

  // Header byte count minus one
  localparam logic [1:0] HdrLastCnt = 2'd3;

  // One decoded frame
  typedef struct packed {
    logic signed [FrameW-1:0] frame_number;
    logic [StateW-1:0]        sim_state;
    logic [DblW-1:0]          interval_bits;
    logic [DblW-1:0]          control_bits;
    logic [DblW-1:0]          setpoint_bits;
    logic [OutLenW-1:0]       payload_length;
  } result_t;

endpackage

// ----- design/lpfd_parser.sv -----
// Header gathering, payload field capture and result assembly per byte.
// Depends on lpfd_pkg.
module lpfd_parser import lpfd_pkg::*; #(
  parameter int unsigned MaxPayload = MaxPayloadDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] data_byte_i,
  output logic             last_o,
  output logic             done_o,
  output result_t          result_o
);

  localparam int unsigned LenW = $clog2(MaxPayload + 1);

  logic            in_payload_q, in_payload_d;
  logic [1:0]      hdr_cnt_q, hdr_cnt_d;
  logic [HdrW-1:0] hdr_q, hdr_d;
  logic [LenW-1:0] flen_q, flen_d;
  logic [LenW-1:0] pcnt_q, pcnt_d;
  logic [FrameW-1:0] frame_q, frame_d;
  logic [StateW-1:0] state_q, state_d;
  logic [DblW-1:0]   intv_q, intv_d;
  logic [DblW-1:0]   ctrl_q, ctrl_d;
  logic [DblW-1:0]   setp_q, setp_d;
  logic [HdrW-1:0]   hdr_shift;
  logic [LenW-1:0]   pcnt_inc;
  logic              hdr_ok;
  logic [LenW+OutLenW-1:0] len_ext;

  assign hdr_shift = {hdr_q[HdrW-ByteW-1:0], data_byte_i};
  assign hdr_ok    = (hdr_shift != '0) && (hdr_shift <= HdrW'(MaxPayload));
  assign pcnt_inc  = pcnt_q + LenW'(1);
  // The next byte closes the frame; depends on state only
  assign last_o    = in_payload_q && (pcnt_inc == flen_q);
  assign done_o    = accept_i && last_o;

  // Next state for one transaction
  always_comb begin
    in_payload_d = in_payload_q;
    hdr_cnt_d    = hdr_cnt_q;
    hdr_d        = hdr_q;
    flen_d       = flen_q;
    pcnt_d       = pcnt_q;
    frame_d      = frame_q;
    state_d      = state_q;
    intv_d       = intv_q;
    ctrl_d       = ctrl_q;
    setp_d       = setp_q;
    if (!in_payload_q) begin
      if (hdr_cnt_q != HdrLastCnt) begin
        hdr_cnt_d = hdr_cnt_q + 2'd1;
        hdr_d     = hdr_shift;
      end else begin
        hdr_cnt_d = '0;
        hdr_d     = '0;
        if (hdr_ok) begin
          flen_d       = hdr_shift[LenW-1:0];
          pcnt_d       = '0;
          in_payload_d = 1'b1;
          frame_d      = '0;
          state_d      = '0;
          intv_d       = '0;
          ctrl_d       = '0;
          setp_d       = '0;
        end
      end
    end else begin
      // Shift the byte into the field that owns this offset
      priority if (pcnt_q <= LenW'(FrameLast)) begin
        frame_d = {frame_q[FrameW-ByteW-1:0], data_byte_i};
      end else if (pcnt_q == LenW'(StateLast)) begin
        state_d = data_byte_i;
      end else if (pcnt_q <= LenW'(IntervalLast)) begin
        intv_d = {intv_q[DblW-ByteW-1:0], data_byte_i};
      end else if (pcnt_q <= LenW'(ControlLast)) begin
        ctrl_d = {ctrl_q[DblW-ByteW-1:0], data_byte_i};
      end else if (pcnt_q <= LenW'(SetpointLast)) begin
        setp_d = {setp_q[DblW-ByteW-1:0], data_byte_i};
      end else begin
        // skip bytes past the last field
      end
      pcnt_d = pcnt_inc;
      if (last_o) begin
        in_payload_d = 1'b0;
        pcnt_d       = '0;
        flen_d       = '0;
        hdr_cnt_d    = '0;
        hdr_d        = '0;
      end
    end
  end

  // Assemble the result from the updated fields; short fields read zero
  assign len_ext = {{OutLenW{1'b0}}, flen_q};
  always_comb begin
    result_o.frame_number   = (flen_q > LenW'(FrameLast)) ? frame_d : '0;
    result_o.sim_state      = (flen_q > LenW'(StateLast)) ? state_d : '0;
    result_o.interval_bits  = (flen_q > LenW'(IntervalLast)) ? intv_d : '0;
    result_o.control_bits   = (flen_q > LenW'(ControlLast)) ? ctrl_d : '0;
    result_o.setpoint_bits  = (flen_q > LenW'(SetpointLast)) ? setp_d : '0;
    result_o.payload_length = len_ext[OutLenW-1:0];
  end

  // Hold or advance the parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      hdr_cnt_q    <= '0;
      hdr_q        <= '0;
      flen_q       <= '0;
      pcnt_q       <= '0;
      frame_q      <= '0;
      state_q      <= '0;
      intv_q       <= '0;
      ctrl_q       <= '0;
      setp_q       <= '0;
    end else if (accept_i) begin
      in_payload_q <= in_payload_d;
      hdr_cnt_q    <= hdr_cnt_d;
      hdr_q        <= hdr_d;
      flen_q       <= flen_d;
      pcnt_q       <= pcnt_d;
      frame_q      <= last_o ? '0 : frame_d;
      state_q      <= last_o ? '0 : state_d;
      intv_q       <= last_o ? '0 : intv_d;
      ctrl_q       <= last_o ? '0 : ctrl_d;
      setp_q       <= last_o ? '0 : setp_d;
    end
  end

endmodule

// ----- design/length_prefixed_frame_deframer_unit.sv -----
// Top level of the length-prefixed frame deframer: parser plus result register.
// Depends on lpfd_pkg and lpfd_parser.
//
//   channel  direction  handshake             payload
//   in       input      in_valid_i/in_stall_o  data_byte_i
//   out      output     out_valid_o/out_stall_i frame_number_o .. payload_length_o
//
// One byte is taken per cycle unless the input stalls; the parser updates its
// counters and field shift registers in the cycle the transaction completes.
// The frame's last byte loads the result register, whose output shows in the
// next cycle. Input stalls only when the next byte closes a frame while a result
// still waits in the register. Reset clears all parser state and the result valid.
module length_prefixed_frame_deframer_unit import lpfd_pkg::*; #(
  parameter int unsigned MaxPayload = MaxPayloadDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ByteW-1:0]         data_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [FrameW-1:0] frame_number_o,
  output logic [StateW-1:0]        sim_state_o,
  output logic [DblW-1:0]          interval_bits_o,
  output logic [DblW-1:0]          control_bits_o,
  output logic [DblW-1:0]          setpoint_bits_o,
  output logic [OutLenW-1:0]       payload_length_o
);

  logic    accept;
  logic    last;
  logic    done;
  logic    out_valid_q;
  result_t result;
  result_t res_q;

  assign in_stall_o = last && out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  lpfd_parser #(
    .MaxPayload (MaxPayload)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .last_o      (last),
    .done_o      (done),
    .result_o    (result)
  );

  // Set on a finished frame, drop once the transaction is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (done) begin
      res_q <= result;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_number_o   = res_q.frame_number;
  assign sim_state_o      = res_q.sim_state;
  assign interval_bits_o  = res_q.interval_bits;
  assign control_bits_o   = res_q.control_bits;
  assign setpoint_bits_o  = res_q.setpoint_bits;
  assign payload_length_o = res_q.payload_length;

endmodule
